>>> rtl/pfcf_pkg.sv
`timescale 1ns / 1ps
package pfcf_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_IPV6   = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [15:0] ETH_HDR    = 16'd14;
    localparam logic [15:0] V4_MIN     = 16'd34;
    localparam logic [15:0] V6_MIN     = 16'd54;
    localparam logic [15:0] LFSR_SEED  = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TCP  = 2'd1;
    localparam logic [1:0] KIND_UDP  = 2'd2;
    localparam logic [1:0] KIND_ICMP = 2'd3;

    typedef enum logic [2:0] {
        VERDICT_EMIT      = 3'd0,
        VERDICT_SKIP      = 3'd1,
        VERDICT_V4_SHORT  = 3'd2,
        VERDICT_IHL_SHORT = 3'd3,
        VERDICT_V6_SHORT  = 3'd4,
        VERDICT_CUTOFF    = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        CFG_CUTOFF    = 2'd0,
        CFG_MAX_FLOWS = 2'd1,
        CFG_MAX_IDLE  = 2'd2,
        CFG_SWEEP     = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_SWEEP,
        ST_ECHECK,
        ST_EVICT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [63:0] sh;
        logic [63:0] sl;
        logic [63:0] dh;
        logic [63:0] dl;
        logic [33:0] pk;
    } flow_key_t;

    typedef struct packed {
        logic        valid;
        flow_key_t   key;
        logic [31:0] total;
        logic [31:0] seen;
    } entry_t;

    typedef struct packed {
        verdict_t    verdict;
        flow_key_t   key;
        logic [15:0] payload;
        logic [15:0] l3_len;
    } pkt_t;

    function automatic logic exceeds(input logic [31:0] now, input logic [31:0] then_t,
                                     input logic [31:0] limit);
        exceeds = (now < then_t) || ((now - then_t) > limit);
    endfunction

endpackage

>>> rtl/pfcf_table_ram.sv
`timescale 1ns / 1ps
module pfcf_table_ram
    import pfcf_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/pfcf_classify.sv
`timescale 1ns / 1ps
module pfcf_classify
    import pfcf_pkg::*;
(
    input  logic [15:0] ether_type,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  ip_protocol,
    input  logic [63:0] source_address_high,
    input  logic [63:0] source_address_low,
    input  logic [63:0] destination_address_high,
    input  logic [63:0] destination_address_low,
    input  logic [15:0] first_transport_word,
    input  logic [15:0] second_transport_word,
    input  logic [3:0]  tcp_offset_words,
    input  logic [15:0] wire_length,
    output pkt_t        pkt
);

    logic [6:0]  ip_hdr;
    logic [6:0]  l4_hdr;
    logic [7:0]  hdr_sum;
    logic [15:0] l3_len;
    logic [1:0]  kind;
    logic [15:0] w1;
    logic [15:0] w2;

    always_comb
    begin
        pkt.verdict = VERDICT_EMIT;
        pkt.key.sh  = source_address_high;
        pkt.key.sl  = source_address_low;
        pkt.key.dh  = destination_address_high;
        pkt.key.dl  = destination_address_low;
        ip_hdr      = 7'd40;
        if (ether_type == ETH_IPV4)
        begin
            ip_hdr = {1'b0, ip_header_words, 2'b00};
            if (wire_length < V4_MIN)
            begin
                pkt.verdict = VERDICT_V4_SHORT;
            end
            else if (ip_header_words < 4'd5)
            begin
                pkt.verdict = VERDICT_IHL_SHORT;
            end
            // map to ::ffff:a.b.c.d
            pkt.key.sh = '0;
            pkt.key.sl = {32'h0000FFFF, source_address_low[31:0]};
            pkt.key.dh = '0;
            pkt.key.dl = {32'h0000FFFF, destination_address_low[31:0]};
        end
        else if (ether_type == ETH_IPV6)
        begin
            if (wire_length < V6_MIN)
            begin
                pkt.verdict = VERDICT_V6_SHORT;
            end
        end
        else
        begin
            pkt.verdict = VERDICT_SKIP;
        end

        kind = KIND_NONE;
        w1   = '0;
        w2   = '0;
        l4_hdr = '0;
        case (ip_protocol)
            PROTO_TCP:
            begin
                kind   = KIND_TCP;
                w1     = first_transport_word;
                w2     = second_transport_word;
                l4_hdr = {1'b0, tcp_offset_words, 2'b00};
            end
            PROTO_UDP:
            begin
                kind   = KIND_UDP;
                w1     = first_transport_word;
                w2     = second_transport_word;
                l4_hdr = 7'd8;
            end
            PROTO_ICMP:
            begin
                kind   = KIND_ICMP;
                w1     = {8'd0, first_transport_word[7:0]};
                w2     = {8'd0, second_transport_word[7:0]};
                l4_hdr = 7'd8;
            end
            default:
            begin
                kind = KIND_NONE;
            end
        endcase
        pkt.key.pk = {kind, w1, w2};

        l3_len      = wire_length - ETH_HDR;
        hdr_sum     = {1'b0, ip_hdr} + {1'b0, l4_hdr};
        pkt.l3_len  = l3_len;
        pkt.payload = (l3_len > {8'd0, hdr_sum}) ? (l3_len - {8'd0, hdr_sum}) : 16'd0;
    end

endmodule

>>> rtl/packet_flow_cutoff_filter_core.sv
`timescale 1ns / 1ps
// A rejected packet goes straight to its result word. An IP packet scans the whole flow
// table and writes its entry; a cutoff drop then ends, else an idle sweep follows when one
// is due and an eviction walk when the table is at its flow limit. Throughput: one packet at
// a time; the next word is taken once the result has registered and the block is back in
// idle, and a stalled result holds the block. The single read port of the flow table, walked
// once a cycle, sets the pace. Reset: asynchronous, active low; then a clear, input stalled.
module packet_flow_cutoff_filter_core
    import pfcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] ether_type,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  ip_protocol,
    input  logic [63:0] source_address_high,
    input  logic [63:0] source_address_low,
    input  logic [63:0] destination_address_high,
    input  logic [63:0] destination_address_low,
    input  logic [15:0] first_transport_word,
    input  logic [15:0] second_transport_word,
    input  logic [3:0]  tcp_offset_words,
    input  logic [15:0] wire_length,
    input  logic [31:0] arrival_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  verdict,
    output logic [15:0] emit_length,
    output logic        new_flow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    state_t      state_reg, state_next;
    logic [31:0] cutoff_reg, idle_reg, intv_reg, lst_reg, lst_next;
    logic [10:0] maxf_reg, occ_reg, occ_next;
    logic [15:0] lfsr_reg, lfsr_next;
    logic        out_valid_reg, out_valid_next;
    logic        pend_reg, pend_next;
    logic [ADDR_W-1:0] addr_reg, addr_next, idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, ex_reg, ex_next;

    pkt_t        pkt_reg, pkt_next;
    logic [31:0] now_reg, now_next;
    logic        hit_reg, hit_next, free_reg, free_next;
    logic [ADDR_W-1:0] hit_slot_reg, hit_slot_next, free_slot_reg, free_slot_next;
    logic [31:0] hit_total_reg, hit_total_next;
    verdict_t    res_verdict_reg, res_verdict_next, out_verdict_reg, out_verdict_next;
    logic [15:0] res_len_reg, res_len_next, out_len_reg, out_len_next;
    logic        res_new_reg, res_new_next, out_new_reg, out_new_next;

    pkt_t              cls;
    entry_t            rd_data, wr_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic              issue, last;
    logic [ADDR_W-1:0] slot;
    logic [31:0]       old_total, new_total;
    logic [32:0]       sum33, excess;
    logic [10:0]       limit;
    logic [15:0]       lfsr_adv;

    pfcf_classify u_classify (
        .ether_type               (ether_type),
        .ip_header_words          (ip_header_words),
        .ip_protocol              (ip_protocol),
        .source_address_high      (source_address_high),
        .source_address_low       (source_address_low),
        .destination_address_high (destination_address_high),
        .destination_address_low  (destination_address_low),
        .first_transport_word     (first_transport_word),
        .second_transport_word    (second_transport_word),
        .tcp_offset_words         (tcp_offset_words),
        .wire_length              (wire_length),
        .pkt                      (cls)
    );

    pfcf_table_ram u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign verdict     = out_verdict_reg;
    assign emit_length = out_len_reg;
    assign new_flow    = out_new_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cutoff_reg    <= 32'd65536;
            maxf_reg      <= 11'd1024;
            idle_reg      <= 32'd60;
            intv_reg      <= 32'd10;
            lst_reg       <= '0;
            occ_reg       <= '0;
            lfsr_reg      <= LFSR_SEED;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            ex_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lst_reg       <= lst_next;
            occ_reg       <= occ_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            ex_reg        <= ex_next;
            if (cfg_valid)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CUTOFF:    cutoff_reg <= cfg_data;
                    CFG_MAX_FLOWS: maxf_reg   <= cfg_data[10:0];
                    CFG_MAX_IDLE:  idle_reg   <= cfg_data;
                    CFG_SWEEP:     intv_reg   <= cfg_data;
                    default:       cutoff_reg <= cutoff_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg         <= pkt_next;
        now_reg         <= now_next;
        idx_reg         <= idx_next;
        hit_reg         <= hit_next;
        free_reg        <= free_next;
        hit_slot_reg    <= hit_slot_next;
        free_slot_reg   <= free_slot_next;
        hit_total_reg   <= hit_total_next;
        res_verdict_reg <= res_verdict_next;
        res_len_reg     <= res_len_next;
        res_new_reg     <= res_new_next;
        out_verdict_reg <= out_verdict_next;
        out_len_reg     <= out_len_next;
        out_new_reg     <= out_new_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        lst_next         = lst_reg;
        occ_next         = occ_reg;
        lfsr_next        = lfsr_reg;
        out_valid_next   = out_valid_reg;
        pend_next        = 1'b0;
        addr_next        = addr_reg;
        cnt_next         = cnt_reg;
        ex_next          = ex_reg;
        pkt_next         = pkt_reg;
        now_next         = now_reg;
        idx_next         = idx_reg;
        hit_next         = hit_reg;
        free_next        = free_reg;
        hit_slot_next    = hit_slot_reg;
        free_slot_next   = free_slot_reg;
        hit_total_next   = hit_total_reg;
        res_verdict_next = res_verdict_reg;
        res_len_next     = res_len_reg;
        res_new_next     = res_new_reg;
        out_verdict_next = out_verdict_reg;
        out_len_next     = out_len_reg;
        out_new_next     = out_new_reg;
        wr_en            = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = rd_data;

        issue     = (cnt_reg < CNT_W'(TABLE_DEPTH));
        last      = pend_reg && (ex_reg == CNT_W'(TABLE_DEPTH - 1));
        // a full table with no match overwrites slot 0
        slot      = hit_reg ? hit_slot_reg : (free_reg ? free_slot_reg : '0);
        old_total = hit_reg ? hit_total_reg : 32'd0;
        sum33     = {1'b0, old_total} + {17'd0, pkt_reg.payload};
        excess    = sum33 - {1'b0, cutoff_reg};
        new_total = old_total;
        limit     = (maxf_reg == 11'd0) ? 11'd1 :
                    (maxf_reg > 11'(TABLE_DEPTH)) ? 11'(TABLE_DEPTH) : maxf_reg;
        lfsr_adv  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // walk the table one entry a cycle, one read ahead of the data
        if (state_reg == ST_SCAN || state_reg == ST_SWEEP || state_reg == ST_EVICT)
        begin
            pend_next = issue;
            idx_next  = addr_reg;
            if (issue)
            begin
                addr_next = (addr_reg == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : addr_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end
            if (pend_reg)
            begin
                ex_next = ex_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_addr   = addr_reg;
                wr_data   = '0;
                addr_next = addr_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pkt_next = cls;
                    now_next = arrival_seconds;
                    if (cls.verdict != VERDICT_EMIT)
                    begin
                        res_verdict_next = cls.verdict;
                        res_len_next     = '0;
                        res_new_next     = 1'b0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        if (lst_reg == 32'd0)
                        begin
                            lst_next = arrival_seconds;
                        end
                        addr_next  = '0;
                        cnt_next   = '0;
                        ex_next    = '0;
                        hit_next   = 1'b0;
                        free_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (!hit_reg && rd_data.valid && rd_data.key == pkt_reg.key)
                    begin
                        hit_next       = 1'b1;
                        hit_slot_next  = idx_reg;
                        hit_total_next = rd_data.total;
                    end
                    if (!free_reg && !rd_data.valid)
                    begin
                        free_next      = 1'b1;
                        free_slot_next = idx_reg;
                    end
                end
                if (last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                res_new_next = !hit_reg;
                if (!hit_reg && free_reg)
                begin
                    occ_next = occ_reg + 1'b1;
                end
                if (old_total == cutoff_reg)
                begin
                    res_verdict_next = VERDICT_CUTOFF;
                    res_len_next     = '0;
                    state_next       = ST_DONE;
                end
                else
                begin
                    res_verdict_next = VERDICT_EMIT;
                    if (sum33 <= {1'b0, cutoff_reg})
                    begin
                        new_total    = sum33[31:0];
                        res_len_next = pkt_reg.l3_len;
                    end
                    else
                    begin
                        // trim the packet that crosses the budget
                        new_total    = cutoff_reg;
                        res_len_next = pkt_reg.l3_len - excess[15:0];
                    end
                    addr_next = '0;
                    cnt_next  = '0;
                    ex_next   = '0;
                    if (exceeds(now_reg, lst_reg, intv_reg))
                    begin
                        lst_next   = now_reg;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_ECHECK;
                    end
                end
                wr_en         = 1'b1;
                wr_addr       = slot;
                wr_data.valid = 1'b1;
                wr_data.key   = pkt_reg.key;
                wr_data.total = new_total;
                wr_data.seen  = now_reg;
            end
            ST_SWEEP:
            begin
                if (pend_reg && rd_data.valid && exceeds(now_reg, rd_data.seen, idle_reg))
                begin
                    wr_en         = 1'b1;
                    wr_data.valid = 1'b0;
                    occ_next      = occ_reg - 1'b1;
                end
                if (last)
                begin
                    state_next = ST_ECHECK;
                end
            end
            ST_ECHECK:
            begin
                if (occ_reg != 11'd0 && occ_reg >= limit)
                begin
                    lfsr_next  = lfsr_adv;
                    addr_next  = ADDR_W'(lfsr_adv % TABLE_DEPTH);
                    cnt_next   = '0;
                    ex_next    = '0;
                    state_next = ST_EVICT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_EVICT:
            begin
                if (pend_reg && rd_data.valid)
                begin
                    wr_en         = 1'b1;
                    wr_data.valid = 1'b0;
                    occ_next      = occ_reg - 1'b1;
                    pend_next     = 1'b0;
                    state_next    = ST_DONE;
                end
                else if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = res_verdict_reg;
                    out_len_next     = res_len_reg;
                    out_new_next     = res_new_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/pfcf_checker.sv
`timescale 1ns / 1ps
module pfcf_checker
    import pfcf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  verdict,
    input logic [15:0] emit_length,
    input logic        new_flow
);

    // hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict))
        else $error("stalled result word changed");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict != VERDICT_EMIT |-> emit_length == 16'd0)
        else $error("length on a non-emit verdict");

    a_reject_no_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == VERDICT_SKIP || verdict == VERDICT_V4_SHORT ||
        verdict == VERDICT_IHL_SHORT || verdict == VERDICT_V6_SHORT) |-> !new_flow)
        else $error("rejected packet created a flow");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict <= VERDICT_CUTOFF)
        else $error("verdict out of range");

endmodule

bind packet_flow_cutoff_filter_core pfcf_checker u_pfcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .verdict     (verdict),
    .emit_length (emit_length),
    .new_flow    (new_flow)
);

>>> tb/sv/flow_cutoff_checker.sv
`timescale 1ns / 1ps
module flow_cutoff_checker
    import pfcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] ether_type,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  ip_protocol,
    input  logic [63:0] source_address_high,
    input  logic [63:0] source_address_low,
    input  logic [63:0] destination_address_high,
    input  logic [63:0] destination_address_low,
    input  logic [15:0] first_transport_word,
    input  logic [15:0] second_transport_word,
    input  logic [3:0]  tcp_offset_words,
    input  logic [15:0] wire_length,
    input  logic [31:0] arrival_seconds,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  verdict,
    input  logic [15:0] emit_length,
    input  logic        new_flow,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct {
        verdict_t    vd;
        logic [15:0] len;
        logic        nf;
    } flow_result_t;

    flow_result_t expected_results[$];
    int           mismatch_count;

    logic [31:0] byte_cutoff;
    logic [10:0] flow_limit;
    logic [31:0] idle_limit;
    logic [31:0] sweep_period;

    logic        tbl_valid [TABLE_DEPTH];
    logic [63:0] tbl_sh    [TABLE_DEPTH];
    logic [63:0] tbl_sl    [TABLE_DEPTH];
    logic [63:0] tbl_dh    [TABLE_DEPTH];
    logic [63:0] tbl_dl    [TABLE_DEPTH];
    logic [33:0] tbl_pk    [TABLE_DEPTH];
    logic [31:0] tbl_total [TABLE_DEPTH];
    logic [31:0] tbl_seen  [TABLE_DEPTH];
    logic [31:0] sweep_mark;
    int          flow_count;
    logic [15:0] victim_seed;

    function automatic logic past_limit(input logic [31:0] now_v, input logic [31:0] then_v,
                                        input logic [31:0] lim);
        past_limit = (now_v < then_v) || ((now_v - then_v) > lim);
    endfunction

    function automatic void free_slot(input int s);
        tbl_valid[s] = 1'b0;
        if (flow_count > 0)
            flow_count--;
    endfunction

    function automatic flow_result_t predict_flow_verdict();
        logic [63:0]  sh, sl, dh, dl;
        logic [15:0]  w1, w2;
        logic [31:0]  psize, iph, l4, pay, now_v, eff;
        logic [1:0]   kind;
        logic [33:0]  pk;
        logic [32:0]  total;
        logic         lsb;
        int           hit, st, s;
        flow_result_t r;
        r.vd = VERDICT_EMIT;
        r.len = '0;
        r.nf = 1'b0;
        sh = source_address_high;
        sl = source_address_low;
        dh = destination_address_high;
        dl = destination_address_low;
        w1 = first_transport_word;
        w2 = second_transport_word;
        now_v = arrival_seconds;
        l4 = '0;
        kind = KIND_NONE;
        if (ether_type == ETH_IPV4)
        begin
            if (wire_length < V4_MIN)
            begin
                r.vd = VERDICT_V4_SHORT;
                return r;
            end
            iph = {26'd0, ip_header_words, 2'b00};
            if (iph < 32'd20)
            begin
                r.vd = VERDICT_IHL_SHORT;
                return r;
            end
            sh = '0;
            sl = {32'h0000FFFF, sl[31:0]};
            dh = '0;
            dl = {32'h0000FFFF, dl[31:0]};
        end
        else if (ether_type == ETH_IPV6)
        begin
            if (wire_length < V6_MIN)
            begin
                r.vd = VERDICT_V6_SHORT;
                return r;
            end
            iph = 32'd40;
        end
        else
        begin
            r.vd = VERDICT_SKIP;
            return r;
        end
        psize = {16'd0, wire_length} - {16'd0, ETH_HDR};
        if (ip_protocol == PROTO_TCP)
        begin
            kind = KIND_TCP;
            l4 = {26'd0, tcp_offset_words, 2'b00};
        end
        else if (ip_protocol == PROTO_UDP)
        begin
            kind = KIND_UDP;
            l4 = 32'd8;
        end
        else if (ip_protocol == PROTO_ICMP)
        begin
            kind = KIND_ICMP;
            w1 = {8'd0, w1[7:0]};
            w2 = {8'd0, w2[7:0]};
            l4 = 32'd8;
        end
        else
        begin
            w1 = '0;
            w2 = '0;
        end
        pay = (psize > iph + l4) ? psize - iph - l4 : 32'd0;
        pk = {kind, w1, w2};
        if (sweep_mark == 32'd0)
            sweep_mark = now_v;

        hit = -1;
        for (s = 0; s < TABLE_DEPTH && hit < 0; s++)
            if (tbl_valid[s] && tbl_sh[s] == sh && tbl_sl[s] == sl && tbl_dh[s] == dh &&
                tbl_dl[s] == dl && tbl_pk[s] == pk)
                hit = s;
        if (hit < 0)
        begin
            for (s = 0; s < TABLE_DEPTH && hit < 0; s++)
                if (!tbl_valid[s])
                    hit = s;
            if (hit < 0)
                hit = 0;
            if (!tbl_valid[hit])
                flow_count++;
            tbl_valid[hit] = 1'b1;
            tbl_sh[hit] = sh;
            tbl_sl[hit] = sl;
            tbl_dh[hit] = dh;
            tbl_dl[hit] = dl;
            tbl_pk[hit] = pk;
            tbl_total[hit] = '0;
            r.nf = 1'b1;
        end
        tbl_seen[hit] = now_v;

        if (tbl_total[hit] == byte_cutoff)
        begin
            r.vd = VERDICT_CUTOFF;
            return r;
        end
        total = {1'b0, tbl_total[hit]} + {1'b0, pay};
        if (total <= {1'b0, byte_cutoff})
        begin
            tbl_total[hit] = total[31:0];
        end
        else
        begin
            psize = psize - 32'(total - {1'b0, byte_cutoff});
            tbl_total[hit] = byte_cutoff;
        end

        if (past_limit(now_v, sweep_mark, sweep_period))
        begin
            sweep_mark = now_v;
            for (s = 0; s < TABLE_DEPTH; s++)
                if (tbl_valid[s] && past_limit(now_v, tbl_seen[s], idle_limit))
                    free_slot(s);
        end

        eff = (flow_limit == 11'd0) ? 32'd1 : {21'd0, flow_limit};
        if (eff > TABLE_DEPTH)
            eff = TABLE_DEPTH;
        if (flow_count > 0 && flow_count >= int'(eff))
        begin
            lsb = victim_seed[0];
            victim_seed = victim_seed >> 1;
            if (lsb)
                victim_seed = victim_seed ^ LFSR_TAPS;
            st = int'(victim_seed) % TABLE_DEPTH;
            hit = -1;
            for (s = 0; s < TABLE_DEPTH && hit < 0; s++)
                if (tbl_valid[(st + s) % TABLE_DEPTH])
                    hit = (st + s) % TABLE_DEPTH;
            if (hit >= 0)
                free_slot(hit);
        end
        r.len = psize[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        flow_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            mismatch_count = 0;
            byte_cutoff = 32'd65536;
            flow_limit = 11'd1024;
            idle_limit = 32'd60;
            sweep_period = 32'd10;
            for (int i = 0; i < TABLE_DEPTH; i++)
                tbl_valid[i] = 1'b0;
            sweep_mark = '0;
            flow_count = 0;
            victim_seed = LFSR_SEED;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CUTOFF:    byte_cutoff = cfg_data;
                    CFG_MAX_FLOWS: flow_limit = cfg_data[10:0];
                    CFG_MAX_IDLE:  idle_limit = cfg_data;
                    CFG_SWEEP:     sweep_period = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected word", {29'd0, verdict}, 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (verdict !== want.vd)
                        report_mismatch("verdict", {29'd0, verdict}, {29'd0, want.vd});
                    if (emit_length !== want.len)
                        report_mismatch("emit_length", {16'd0, emit_length}, {16'd0, want.len});
                    if (new_flow !== want.nf)
                        report_mismatch("new_flow", {31'd0, new_flow}, {31'd0, want.nf});
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_flow_verdict());
            errors <= mismatch_count;
            pending <= expected_results.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    import pfcf_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd40_000_000;
    localparam int     SETTLE      = 3 * TABLE_DEPTH + 100;
    localparam int     POOL        = 24;
    localparam int     PER_PHASE   = 330;
    localparam int     PHASES      = 6;

    typedef struct {
        logic [15:0] et;
        logic [3:0]  ihl;
        logic [7:0]  pr;
        logic [63:0] sh, sl, dh, dl;
        logic [15:0] w1, w2;
        logic [3:0]  tof;
        logic [15:0] wl;
        logic [31:0] ts;
    } pkt_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] ether_type;
    logic [3:0]  ip_header_words;
    logic [7:0]  ip_protocol;
    logic [63:0] source_address_high;
    logic [63:0] source_address_low;
    logic [63:0] destination_address_high;
    logic [63:0] destination_address_low;
    logic [15:0] first_transport_word;
    logic [15:0] second_transport_word;
    logic [3:0]  tcp_offset_words;
    logic [15:0] wire_length;
    logic [31:0] arrival_seconds;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  verdict;
    logic [15:0] emit_length;
    logic        new_flow;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;

    int          send_idle_pct = 26;
    int          recv_idle_pct = 63;
    longint      cycles = 0;
    logic [31:0] now_s = 32'd100;
    pkt_word_t   flow_pool [POOL];

    packet_flow_cutoff_filter_core uut (.*);
    flow_cutoff_checker chk (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_pkt(input pkt_word_t p);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        ether_type <= p.et;
        ip_header_words <= p.ihl;
        ip_protocol <= p.pr;
        source_address_high <= p.sh;
        source_address_low <= p.sl;
        destination_address_high <= p.dh;
        destination_address_low <= p.dl;
        first_transport_word <= p.w1;
        second_transport_word <= p.w2;
        tcp_offset_words <= p.tof;
        wire_length <= p.wl;
        arrival_seconds <= p.ts;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // drop valid and hold until every word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        rand64 = {$urandom, $urandom};
    endfunction

    function automatic pkt_word_t make_flow();
        pkt_word_t p;
        int        c;
        c = $urandom_range(3);
        p.et = $urandom_range(1) ? ETH_IPV4 : ETH_IPV6;
        p.ihl = 4'($urandom_range(5, 15));
        p.pr = (c == 0) ? PROTO_TCP : (c == 1) ? PROTO_UDP : (c == 2) ? PROTO_ICMP : 8'($urandom);
        p.sh = rand64();
        p.sl = rand64();
        p.dh = rand64();
        p.dl = rand64();
        p.w1 = 16'($urandom);
        p.w2 = 16'($urandom);
        p.tof = 4'($urandom);
        p.wl = 16'd600;
        p.ts = now_s;
        return p;
    endfunction

    function automatic logic [31:0] tick();
        if ($urandom_range(49) == 0 && now_s > 60)
            now_s = now_s - $urandom_range(50);
        else
            now_s = now_s + $urandom_range(3);
        return now_s;
    endfunction

    function automatic pkt_word_t make_random_pkt();
        pkt_word_t p;
        if ($urandom_range(99) < 20)
        begin
            p = make_flow();
            p.et = 16'($urandom);
            p.ihl = 4'($urandom);
            p.wl = 16'($urandom);
            p.ts = ($urandom_range(9) == 0) ? $urandom : tick();
        end
        else
        begin
            p = flow_pool[$urandom_range(POOL - 1)];
            p.wl = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(54, 1500));
            p.ts = tick();
        end
        return p;
    endfunction

    initial
    begin
        pkt_word_t p;
        in_valid <= 1'b0;
        ether_type <= '0;
        ip_header_words <= '0;
        ip_protocol <= '0;
        source_address_high <= '0;
        source_address_low <= '0;
        destination_address_high <= '0;
        destination_address_low <= '0;
        first_transport_word <= '0;
        second_transport_word <= '0;
        tcp_offset_words <= '0;
        wire_length <= '0;
        arrival_seconds <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CUTOFF;
        cfg_data <= '0;
        for (int i = 0; i < POOL; i++)
            flow_pool[i] = make_flow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under reset settings
        p = make_flow();
        p.et = 16'h1234;
        send_pkt(p);
        p = make_flow();
        p.et = ETH_IPV4;
        p.wl = V4_MIN - 16'd1;
        send_pkt(p);
        p.wl = V4_MIN;
        p.ihl = 4'd4;
        send_pkt(p);
        p.ihl = 4'd15;
        p.wl = 16'hFFFF;
        p.pr = PROTO_TCP;
        p.tof = 4'd15;
        send_pkt(p);
        p.wl = V4_MIN;
        send_pkt(p);
        p.ts = p.ts + 1;
        p.pr = PROTO_UDP;
        p.ihl = 4'd5;
        send_pkt(p);
        p.pr = PROTO_ICMP;
        p.w1 = 16'hFFFF;
        p.w2 = 16'hFF00;
        send_pkt(p);
        p.pr = 8'hFF;
        send_pkt(p);
        p.et = ETH_IPV6;
        p.wl = V6_MIN - 16'd1;
        send_pkt(p);
        p.wl = V6_MIN;
        send_pkt(p);
        p.wl = 16'hFFFF;
        p.pr = PROTO_TCP;
        p.tof = 4'd0;
        p.sh = '1;
        p.sl = '1;
        p.dh = '0;
        p.dl = '0;
        send_pkt(p);
        // second packet crosses the default cutoff and is trimmed, third drops
        send_pkt(p);
        send_pkt(p);
        p.ts = 32'd5;
        send_pkt(p);
        p.ts = 32'hFFFF_FFFF;
        send_pkt(p);
        drain();
        repeat (SETTLE) @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_CUTOFF, 3000); write_reg(CFG_MAX_FLOWS, 8);
                    write_reg(CFG_MAX_IDLE, 30); write_reg(CFG_SWEEP, 5);
                end
                1:
                begin
                    write_reg(CFG_CUTOFF, 0); write_reg(CFG_MAX_FLOWS, 1);
                    write_reg(CFG_MAX_IDLE, 0); write_reg(CFG_SWEEP, 0);
                end
                2:
                begin
                    write_reg(CFG_CUTOFF, '1); write_reg(CFG_MAX_FLOWS, 1024);
                    write_reg(CFG_MAX_IDLE, '1); write_reg(CFG_SWEEP, '1);
                end
                3:
                begin
                    write_reg(CFG_CUTOFF, 500); write_reg(CFG_MAX_FLOWS, 0);
                    write_reg(CFG_MAX_IDLE, 10); write_reg(CFG_SWEEP, 3);
                end
                4:
                begin
                    write_reg(CFG_CUTOFF, 20000); write_reg(CFG_MAX_FLOWS, 2047);
                    write_reg(CFG_MAX_IDLE, 100); write_reg(CFG_SWEEP, 20);
                end
                default:
                begin
                    write_reg(CFG_CUTOFF, 1500); write_reg(CFG_MAX_FLOWS, 3);
                    write_reg(CFG_MAX_IDLE, 5); write_reg(CFG_SWEEP, 1);
                end
            endcase
            case (ph % 3)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_idle_pct = 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PER_PHASE; n++)
            begin
                if (ph == 0 && n == PER_PHASE / 2)
                    drain();
                send_pkt(make_random_pkt());
            end
            drain();
            repeat (SETTLE) @(posedge clk);
        end

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
